// File: hdl/tbcc_pkg.sv
// ----------------------------------------------------------------------------
// tbcc_pkg
// Shared types and constants of the touch button click classifier.
// ----------------------------------------------------------------------------
package tbcc_pkg;

   localparam int unsigned CfgWidth  = 16;
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned AddrWidth = 5;
   localparam int unsigned DataWidth = 32;

   typedef enum logic [1:0] {
      CMD_IRQ  = 2'd0,
      CMD_POLL = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_LONG   = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      REG_PRESS_THRESHOLD   = 3'd0,
      REG_HYSTERESIS        = 3'd1,
      REG_LONG_PRESS_MS     = 3'd2,
      REG_DEBOUNCE_MS       = 3'd3,
      REG_MIN_PRESS_MS      = 3'd4,
      REG_RELEASE_STABLE_MS = 3'd5
   } reg_idx_type;

   localparam logic [CfgWidth-1:0] RstPressThreshold   = 16'd0;
   localparam logic [CfgWidth-1:0] RstHysteresis       = 16'd0;
   localparam logic [CfgWidth-1:0] RstLongPressMs      = 16'd1000;
   localparam logic [CfgWidth-1:0] RstDebounceMs       = 16'd50;
   localparam logic [CfgWidth-1:0] RstMinPressMs       = 16'd50;
   localparam logic [CfgWidth-1:0] RstReleaseStableMs  = 16'd30;

   typedef struct packed {
      logic [CfgWidth-1:0] press_threshold;
      logic [CfgWidth-1:0] hysteresis;
      logic [CfgWidth-1:0] long_press_ms;
      logic [CfgWidth-1:0] debounce_ms;
      logic [CfgWidth-1:0] min_press_ms;
      logic [CfgWidth-1:0] release_stable_ms;
   } cfg_type;

endpackage

// File: hdl/tbcc_csr.sv
// ----------------------------------------------------------------------------
// tbcc_csr
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module tbcc_csr
   import tbcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   output logic [DataWidth-1:0] csr_prdata,
   output logic                 csr_pready,
   output cfg_type              cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   reg_idx_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = reg_idx_type'(csr_paddr[AddrWidth-1:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_PRESS_THRESHOLD:   cfg_in.press_threshold   = csr_pwdata[CfgWidth-1:0];
            REG_HYSTERESIS:        cfg_in.hysteresis        = csr_pwdata[CfgWidth-1:0];
            REG_LONG_PRESS_MS:     cfg_in.long_press_ms     = csr_pwdata[CfgWidth-1:0];
            REG_DEBOUNCE_MS:       cfg_in.debounce_ms       = csr_pwdata[CfgWidth-1:0];
            REG_MIN_PRESS_MS:      cfg_in.min_press_ms      = csr_pwdata[CfgWidth-1:0];
            REG_RELEASE_STABLE_MS: cfg_in.release_stable_ms = csr_pwdata[CfgWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_PRESS_THRESHOLD:   csr_prdata = {16'd0, cfg_ff.press_threshold};
         REG_HYSTERESIS:        csr_prdata = {16'd0, cfg_ff.hysteresis};
         REG_LONG_PRESS_MS:     csr_prdata = {16'd0, cfg_ff.long_press_ms};
         REG_DEBOUNCE_MS:       csr_prdata = {16'd0, cfg_ff.debounce_ms};
         REG_MIN_PRESS_MS:      csr_prdata = {16'd0, cfg_ff.min_press_ms};
         REG_RELEASE_STABLE_MS: csr_prdata = {16'd0, cfg_ff.release_stable_ms};
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_threshold   <= RstPressThreshold;
         cfg_ff.hysteresis        <= RstHysteresis;
         cfg_ff.long_press_ms     <= RstLongPressMs;
         cfg_ff.debounce_ms       <= RstDebounceMs;
         cfg_ff.min_press_ms      <= RstMinPressMs;
         cfg_ff.release_stable_ms <= RstReleaseStableMs;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/touch_button_click_classifier.sv
// ----------------------------------------------------------------------------
// touch_button_click_classifier
// Single click / long press classifier for one capacitive touch button.
// ----------------------------------------------------------------------------
// Usage: each req_ transaction carries a command (press interrupt, update
// poll, read-and-clear event), a millisecond timestamp and a touch sample.
// Every request yields exactly one rsp_ transaction with the read event
// (zero for non-read commands) and the press-tracking flag after the step.
// Thresholds and timings are set through the csr_ port; the user must write
// them only while the block is idle, which the block does not enforce;
// pready is always high and reads return the stored value.
// A request is registered, the state is updated by one pass of compare/
// subtract logic, and the result register shows it by raising rsp_valid.
// Throughput: one transaction per cycle while rsp_ready stays high; the
// tracking state is updated in the same edge that loads the result
// register, so a following request sees it at once.
// Stall: when rsp_ready is low the result holds, the input register keeps
// one more request, and req_ready drops only when both are full.
// Reset: synchronous; clears the pipeline, the tracking state and the
// pending event, and loads the register defaults.
// ----------------------------------------------------------------------------
module touch_button_click_classifier
   import tbcc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [31:0]          req_now_ms,
   input  logic [15:0]          req_touch_sample,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_event_res,
   output logic                 rsp_is_pressed,
   // configuration
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [DataWidth-1:0] csr_pwdata,
   output logic [DataWidth-1:0] csr_prdata,
   output logic                 csr_pready
);

   cfg_type cfg;

   tbcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_cmd_ff;
   logic [TimeWidth-1:0] s1_now_ff;
   logic [CfgWidth-1:0]  s1_sample_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_event_ff;
   logic                 rsp_pressed_ff;

   // tracking state
   logic [TimeWidth-1:0] last_irq_ff, last_irq_in;
   logic                 pressed_ff, pressed_in;
   logic [TimeWidth-1:0] press_start_ff, press_start_in;
   logic                 long_seen_ff, long_seen_in;
   logic [TimeWidth-1:0] release_start_ff, release_start_in;
   event_type            pending_ff, pending_in;
   event_type            ev_out;

   logic out_free;
   logic step_fire;
   logic req_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_fire = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_res  = rsp_event_ff;
   assign rsp_is_pressed = rsp_pressed_ff;

   // one step of the classifier
   always_comb begin
      logic [TimeWidth-1:0] since_irq;
      logic [TimeWidth-1:0] held;
      logic [TimeWidth-1:0] rel_base;
      logic [TimeWidth-1:0] stable_time;
      logic [CfgWidth:0]    release_level;
      logic                 above;
      logic                 long_hit;

      last_irq_in      = last_irq_ff;
      pressed_in       = pressed_ff;
      press_start_in   = press_start_ff;
      long_seen_in     = long_seen_ff;
      release_start_in = release_start_ff;
      pending_in       = pending_ff;
      ev_out           = EV_NONE;

      since_irq     = s1_now_ff - last_irq_ff;
      held          = s1_now_ff - press_start_ff;
      // zero start means no release timer is running
      rel_base      = (release_start_ff == '0) ? s1_now_ff : release_start_ff;
      stable_time   = s1_now_ff - rel_base;
      release_level = {1'b0, cfg.press_threshold} + {1'b0, cfg.hysteresis};
      above         = {1'b0, s1_sample_ff} > release_level;
      long_hit      = !long_seen_ff && (held >= {16'd0, cfg.long_press_ms});

      case (s1_cmd_ff)
         CMD_IRQ: begin
            if (since_irq >= {16'd0, cfg.debounce_ms}) begin
               last_irq_in = s1_now_ff;
               if (!pressed_ff) begin
                  pressed_in       = 1'b1;
                  press_start_in   = s1_now_ff;
                  long_seen_in     = 1'b0;
                  release_start_in = '0;
               end
            end
         end
         CMD_POLL: begin
            if (pressed_ff) begin
               if (long_hit) begin
                  pending_in   = EV_LONG;
                  long_seen_in = 1'b1;
               end
               if (above) begin
                  if ((stable_time >= {16'd0, cfg.release_stable_ms}) &&
                      (held >= {16'd0, cfg.min_press_ms})) begin
                     // no click once the long event has fired
                     if (!long_seen_in) begin
                        pending_in = EV_SINGLE;
                     end
                     pressed_in       = 1'b0;
                     release_start_in = '0;
                  end else begin
                     release_start_in = rel_base;
                  end
               end else begin
                  release_start_in = '0;
               end
            end
         end
         CMD_READ: begin
            ev_out     = pending_ff;
            pending_in = EV_NONE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         last_irq_ff      <= '0;
         pressed_ff       <= 1'b0;
         press_start_ff   <= '0;
         long_seen_ff     <= 1'b0;
         release_start_ff <= '0;
         pending_ff       <= EV_NONE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_fire) begin
            last_irq_ff      <= last_irq_in;
            pressed_ff       <= pressed_in;
            press_start_ff   <= press_start_in;
            long_seen_ff     <= long_seen_in;
            release_start_ff <= release_start_in;
            pending_ff       <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff    <= req_cmd;
         s1_now_ff    <= req_now_ms;
         s1_sample_ff <= req_touch_sample;
      end
      if (step_fire) begin
         rsp_event_ff   <= ev_out;
         rsp_pressed_ff <= pressed_in;
      end
   end

`ifndef SYNTHESIS
   a_step_loads_result: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> rsp_valid_ff)
      else $error("processed transaction did not reach the result register");

   a_event_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (step_fire && s1_cmd_ff != CMD_READ) |=> (rsp_event_ff == EV_NONE))
      else $error("event reported for a non-read transaction");

   a_read_clears_event: assert property (@(posedge clock) disable iff (reset)
      (step_fire && s1_cmd_ff == CMD_READ) |=> (pending_ff == EV_NONE))
      else $error("pending event not cleared by read");

   a_release_only_on_poll: assert property (@(posedge clock) disable iff (reset)
      (step_fire && s1_cmd_ff != CMD_POLL && pressed_ff) |=> pressed_ff)
      else $error("press ended outside an update poll");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> (rsp_pressed_ff == pressed_ff))
      else $error("reported press flag differs from tracking state");
`endif

endmodule

// File: tb/sv/touch_button_click_classifier_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_button_click_classifier_test
// Self-checking bench for the touch button click classifier. Press episodes
// (interrupt, bounces, hold polls, release polls, event reads) with random
// timing and samples run under several register settings, mixed with raw
// random commands. A scoreboard predicts every response and checks it in order.
// ----------------------------------------------------------------------------
module touch_button_click_classifier_test;
   import tbcc_pkg::*;

   localparam int RegSlots      = 8;    // 3-bit register index, slots 6 and 7 unused
   localparam int NumPhases     = 7;
   localparam int PhaseItems    = 220;
   localparam int WatchdogLimit = 2000;

   localparam int PhaseAllZero  = 1;
   localparam int PhaseAllMax   = 2;
   localparam int PhaseNoIdle   = 3;
   localparam int PhaseHighThr  = 4;

   // command code with no meaning, must leave the state alone
   localparam logic [1:0] CmdUnused = 2'd3;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_cmd          = '0;
   logic [31:0]          req_now_ms       = '0;
   logic [15:0]          req_touch_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [1:0]           rsp_event_res;
   logic                 rsp_is_pressed;
   logic                 csr_psel         = 1'b0;
   logic                 csr_penable      = 1'b0;
   logic                 csr_pwrite       = 1'b0;
   logic [AddrWidth-1:0] csr_paddr        = '0;
   logic [DataWidth-1:0] csr_pwdata       = '0;
   logic [DataWidth-1:0] csr_prdata;
   logic                 csr_pready;

   bit          idles_on    = 1'b1;
   int          items_sent  = 0;
   int          quiet_count = 0;
   logic [31:0] t_ms        = '0;

   touch_button_click_classifier dut (.*);

   always #2 clock = ~clock;

   class click_scoreboard;
      typedef struct packed {
         logic [1:0] ev;
         logic       pressed;
      } outcome_type;

      cfg_type     cfg;
      logic [31:0] last_irq_ms;
      logic [31:0] press_start_ms;
      logic [31:0] release_start_ms;
      logic        pressed;
      logic        long_seen;
      logic [1:0]  latched_event;
      outcome_type due_outcomes[$];
      int          errors;

      function new();
         cfg.press_threshold   = RstPressThreshold;
         cfg.hysteresis        = RstHysteresis;
         cfg.long_press_ms     = RstLongPressMs;
         cfg.debounce_ms       = RstDebounceMs;
         cfg.min_press_ms      = RstMinPressMs;
         cfg.release_stable_ms = RstReleaseStableMs;
         last_irq_ms      = '0;
         press_start_ms   = '0;
         release_start_ms = '0;
         pressed          = 1'b0;
         long_seen        = 1'b0;
         latched_event    = EV_NONE;
         errors           = 0;
      endfunction

      function logic [16:0] release_level();
         return {1'b0, cfg.press_threshold} + {1'b0, cfg.hysteresis};
      endfunction

      function void set_register(logic [2:0] idx, logic [15:0] value);
         case (idx)
            REG_PRESS_THRESHOLD:   cfg.press_threshold   = value;
            REG_HYSTERESIS:        cfg.hysteresis        = value;
            REG_LONG_PRESS_MS:     cfg.long_press_ms     = value;
            REG_DEBOUNCE_MS:       cfg.debounce_ms       = value;
            REG_MIN_PRESS_MS:      cfg.min_press_ms      = value;
            REG_RELEASE_STABLE_MS: cfg.release_stable_ms = value;
            default: ;
         endcase
      endfunction

      task report(string what);
         errors++;
         if (errors <= 100) begin
            $display("tb: mismatch: %s", what);
         end
      endtask

      task classify_request(logic [1:0] cmd, logic [31:0] stamp, logic [15:0] sample);
         logic [31:0] since_irq;
         logic [31:0] held;
         logic [31:0] above_for;
         logic [1:0]  ev;
         outcome_type outcome;
         ev = EV_NONE;
         case (cmd)
            CMD_IRQ: begin
               since_irq = stamp - last_irq_ms;
               if (since_irq >= {16'h0, cfg.debounce_ms}) begin
                  last_irq_ms = stamp;
                  if (!pressed) begin
                     pressed          = 1'b1;
                     press_start_ms   = stamp;
                     long_seen        = 1'b0;
                     release_start_ms = '0;
                  end
               end
            end
            CMD_POLL: begin
               if (pressed) begin
                  held = stamp - press_start_ms;
                  if (!long_seen && held >= {16'h0, cfg.long_press_ms}) begin
                     latched_event = EV_LONG;
                     long_seen     = 1'b1;
                  end
                  if ({1'b0, sample} > release_level()) begin
                     // zero doubles as "no timer", so a start at time zero restarts later
                     if (release_start_ms == '0) begin
                        release_start_ms = stamp;
                     end
                     above_for = stamp - release_start_ms;
                     if (above_for >= {16'h0, cfg.release_stable_ms} &&
                         held >= {16'h0, cfg.min_press_ms}) begin
                        if (!long_seen) begin
                           latched_event = EV_SINGLE;
                        end
                        pressed          = 1'b0;
                        release_start_ms = '0;
                     end
                  end else begin
                     release_start_ms = '0;
                  end
               end
            end
            CMD_READ: begin
               ev            = latched_event;
               latched_event = EV_NONE;
            end
            default: ;
         endcase
         outcome.ev      = ev;
         outcome.pressed = pressed;
         due_outcomes.push_back(outcome);
      endtask

      task check_classification(logic [1:0] ev, logic busy);
         outcome_type want;
         if (due_outcomes.size() == 0) begin
            report($sformatf("response with none outstanding: event %0d pressed %0d",
                             ev, busy));
            return;
         end
         want = due_outcomes.pop_front();
         if (ev !== want.ev) begin
            report($sformatf("event_res %0d, want %0d", ev, want.ev));
         end
         if (busy !== want.pressed) begin
            report($sformatf("is_pressed %0d, want %0d", busy, want.pressed));
         end
      endtask
   endclass

   click_scoreboard sb = new();

   // response side back-pressure
   always @(posedge clock) begin
      rsp_ready <= !(idles_on && $urandom_range(99) < 12);
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_classification(rsp_event_res, rsp_is_pressed);
         end
         if (req_valid && req_ready) begin
            sb.classify_request(req_cmd, req_now_ms, req_touch_sample);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
            quiet_count = 0;
         end else begin
            quiet_count++;
         end
         if (quiet_count == WatchdogLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [1:0] cmd, input logic [31:0] stamp,
                               input logic [15:0] sample);
      int gap;
      gap = 0;
      while (idles_on && $urandom_range(99) < 12) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_now_ms       <= stamp;
      req_touch_sample <= sample;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.due_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves psel high; load_settings closes the burst
   task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
   endtask

   task automatic load_settings(input logic [15:0] setting[RegSlots]);
      for (int i = 0; i < RegSlots; i++) begin
         write_register(3'(i), setting[i]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [15:0] sample_below();
      logic [16:0] level;
      level = sb.release_level();
      return (level > 17'hFFFF) ? 16'($urandom) : 16'($urandom_range(0, level));
   endfunction

   function automatic logic [15:0] sample_above();
      logic [16:0] level;
      level = sb.release_level();
      return (level >= 17'hFFFF) ? 16'($urandom) : 16'($urandom_range(level + 1, 65535));
   endfunction

   task automatic press_episode();
      int hold_polls;
      int release_polls;
      int bounces;
      hold_polls    = $urandom_range(0, 8);
      release_polls = $urandom_range(0, 6);
      bounces       = $urandom_range(0, 2);
      t_ms += ($urandom_range(9) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 200);
      send_request(CMD_IRQ, t_ms, 16'($urandom));
      repeat (bounces) begin
         t_ms += $urandom_range(0, 60);
         send_request(CMD_IRQ, t_ms, sample_below());
      end
      repeat (hold_polls) begin
         t_ms += ($urandom_range(19) == 0) ? $urandom_range(0, 70000)
                                           : $urandom_range(0, 120);
         send_request(CMD_POLL, t_ms, ($urandom_range(7) == 0) ? sample_above()
                                                               : sample_below());
      end
      repeat (release_polls) begin
         t_ms += $urandom_range(0, 40);
         send_request(CMD_POLL, t_ms, ($urandom_range(9) == 0) ? sample_below()
                                                               : sample_above());
      end
      if ($urandom_range(3) != 0) begin
         send_request(CMD_READ, t_ms, 16'($urandom));
      end
      if ($urandom_range(7) == 0) begin
         send_request(CMD_READ, t_ms + 1, 16'($urandom));
      end
   endtask

   task automatic start_phase(input int phase);
      logic [15:0] setting[RegSlots];
      foreach (setting[i]) setting[i] = 16'($urandom);
      setting[REG_PRESS_THRESHOLD]   = 16'($urandom_range(0, 4000));
      setting[REG_HYSTERESIS]        = 16'($urandom_range(0, 400));
      setting[REG_LONG_PRESS_MS]     = 16'($urandom_range(0, 600));
      setting[REG_DEBOUNCE_MS]       = 16'($urandom_range(0, 80));
      setting[REG_MIN_PRESS_MS]      = 16'($urandom_range(0, 150));
      setting[REG_RELEASE_STABLE_MS] = 16'($urandom_range(0, 100));
      case (phase)
         PhaseAllZero: begin
            for (int i = 0; i <= REG_RELEASE_STABLE_MS; i++) setting[i] = '0;
         end
         PhaseAllMax: begin
            for (int i = 0; i <= REG_RELEASE_STABLE_MS; i++) setting[i] = 16'hFFFF;
         end
         PhaseHighThr: begin
            // release level may run past the sample range
            setting[REG_PRESS_THRESHOLD] = 16'($urandom_range(64500, 65535));
            setting[REG_HYSTERESIS]      = 16'($urandom_range(0, 1500));
         end
         default: ;
      endcase
      idles_on = (phase != PhaseNoIdle);
      load_settings(setting);
      t_ms = ($urandom_range(1) == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3000);
   endtask

   initial begin
      logic [15:0] setting[RegSlots];
      int          target;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: debounce from time zero, wrap, release timer at zero
      send_request(CMD_IRQ, 32'd10, 16'h0000);
      send_request(CMD_POLL, 32'd20, 16'hFFFF);
      send_request(CmdUnused, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(CMD_READ, 32'd30, 16'h0000);
      send_request(CMD_IRQ, 32'hFFFF_FFFF, 16'h0000);
      send_request(CMD_POLL, 32'd0, 16'h0000);
      send_request(CMD_POLL, 32'd0, 16'h0001);
      send_request(CMD_POLL, 32'd40, 16'h0005);
      send_request(CMD_POLL, 32'd80, 16'h0005);
      send_request(CMD_IRQ, 32'd100, 16'h0000);
      send_request(CMD_IRQ, 32'd120, 16'h0000);
      send_request(CMD_IRQ, 32'd160, 16'h0000);
      send_request(CMD_READ, 32'd170, 16'h0000);
      send_request(CMD_POLL, 32'd1100, 16'h0000);
      send_request(CMD_POLL, 32'd1101, 16'h0009);
      send_request(CMD_POLL, 32'd1131, 16'h0009);
      send_request(CMD_READ, 32'd1140, 16'h0000);
      send_request(CMD_READ, 32'd1150, 16'h0000);

      // unreachable release level, zero timings
      wait_drained();
      foreach (setting[i]) setting[i] = 16'($urandom);
      setting[REG_PRESS_THRESHOLD]   = 16'hFFFF;
      setting[REG_HYSTERESIS]        = 16'hFFFF;
      setting[REG_LONG_PRESS_MS]     = '0;
      setting[REG_DEBOUNCE_MS]       = '0;
      setting[REG_MIN_PRESS_MS]      = '0;
      setting[REG_RELEASE_STABLE_MS] = '0;
      load_settings(setting);
      send_request(CMD_IRQ, 32'd5, 16'h0000);
      send_request(CMD_POLL, 32'd5, 16'hFFFF);
      send_request(CMD_IRQ, 32'd5, 16'hFFFF);
      send_request(CMD_READ, 32'd6, 16'h0000);
      send_request(CmdUnused, 32'd6, 16'h0000);

      // release after long press latches no click
      wait_drained();
      setting[REG_PRESS_THRESHOLD] = '0;
      setting[REG_HYSTERESIS]      = '0;
      load_settings(setting);
      send_request(CMD_POLL, 32'd7, 16'h0001);

      for (int phase = 0; phase < NumPhases; phase++) begin
         wait_drained();
         start_phase(phase);
         target = items_sent + PhaseItems;
         while (items_sent < target) begin
            if ($urandom_range(99) < 15) begin
               repeat ($urandom_range(1, 3)) begin
                  send_request(2'($urandom), $urandom, 16'($urandom));
               end
            end else begin
               press_episode();
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.due_outcomes.size() != 0) begin
         sb.report($sformatf("%0d responses never arrived", sb.due_outcomes.size()));
      end
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
